FILE: hw/rtl/gbk_pkg.sv
// ----------------------------------------------------------------------------
// gbk_pkg: shared definitions for the glyph blitter
// Sizes of the glyph, bitmap and kerning stores, command codes, register
// indexes, record types and the grey-level to character mapping.
// ----------------------------------------------------------------------------
package gbk_pkg;

  // Store sizes.
  localparam int GLYPH_SLOTS   = 256;
  localparam int MAX_GLYPH_DIM = 8;
  localparam int KERN_PAIRS    = 64;

  // Derived sizes.
  localparam int GLYPH_AREA = MAX_GLYPH_DIM * MAX_GLYPH_DIM;
  localparam int SLOT_W     = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
  localparam int IDX_W      = (GLYPH_AREA > 1) ? $clog2(GLYPH_AREA) : 1;
  localparam int BMP_DEPTH  = GLYPH_SLOTS * GLYPH_AREA;
  localparam int BMP_AW     = (BMP_DEPTH > 1) ? $clog2(BMP_DEPTH) : 1;
  localparam int KA_W       = (KERN_PAIRS > 1) ? $clog2(KERN_PAIRS) : 1;
  localparam int KC_W       = $clog2(KERN_PAIRS + 1);

  // Command codes.
  localparam logic [1:0] CMD_METRICS = 2'd0;
  localparam logic [1:0] CMD_SAMPLE  = 2'd1;
  localparam logic [1:0] CMD_KERN    = 2'd2;
  localparam logic [1:0] CMD_DRAW    = 2'd3;

  // Register indexes.
  localparam logic [1:0] CFG_BUF_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_BUF_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ASCENDER   = 2'd2;
  localparam logic [1:0] CFG_MAX_GLYPH  = 2'd3;

  // Output characters.
  localparam logic [6:0] CH_SPACE = 7'd32;
  localparam logic [6:0] CH_DOT   = 7'd46;
  localparam logic [6:0] CH_LOW_X = 7'd120;
  localparam logic [6:0] CH_UP_X  = 7'd88;

  // One glyph's metrics as held in the metrics memory.
  typedef struct packed {
    logic [3:0] rows;
    logic [3:0] cols;
    logic [7:0] top;
    logic [7:0] left;
    logic [7:0] advance;
  } metric_t;

  // One kerning pair as held in the kerning memory.
  typedef struct packed {
    logic [7:0] right;
    logic [7:0] left;
    logic [7:0] offset;
  } kern_entry_t;

  // Write request into the kerning unit.
  typedef struct packed {
    logic        en;
    kern_entry_t entry;
  } kern_wr_t;

  // Search request into the kerning unit.
  typedef struct packed {
    logic       start;
    logic [7:0] left;
    logic [7:0] right;
  } kern_req_t;

  // Search status out of the kerning unit.
  typedef struct packed {
    logic       busy;
    logic [7:0] offset;
  } kern_res_t;

  // Maps a grey level onto one of four characters.
  function automatic logic [6:0] level_char(input logic [7:0] v);
    logic [6:0] ch;
    case (v[7:6])
      2'b00:   ch = CH_SPACE;
      2'b01:   ch = CH_DOT;
      2'b10:   ch = CH_LOW_X;
      default: ch = CH_UP_X;
    endcase
    return ch;
  endfunction

endpackage

FILE: hw/rtl/glyph_blit_with_kerning_top.sv
// ----------------------------------------------------------------------------
// glyph_blit_with_kerning_top: glyph store and blitter with kerning
// Loads glyph metrics, bitmaps and kerning pairs, and draws glyphs as a
// stream of pixel writes into a character buffer.
// ----------------------------------------------------------------------------
// The block handles one input beat at a time. Load beats (metrics, bitmap
// sample, kerning pair) are taken in the idle state. A draw first reads the
// glyph metrics, then waits for a scan of the kerning memory at one pair per
// cycle (no pair is scanned when either code is zero), then walks over the
// bitmap: a row step for each row, a column step for each column that is
// clipped or ends a row, and a column step and a pixel step for each written
// pixel, since the bitmap memory's read data is registered; the pixel step
// waits while the output stalls. Glyph valid bits are flip-flops cleared at
// reset, so there is no clearing pass. Each draw ends with a beat that has
// last set; a missing glyph gives a single beat with status set.
// ----------------------------------------------------------------------------
module glyph_blit_with_kerning_top
  import gbk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration writes.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  glyph_code,
  input  logic [7:0]  other_code,
  input  logic signed [10:0] pos_x,
  input  logic signed [10:0] pos_y,
  input  logic [3:0]  glyph_rows,
  input  logic [3:0]  glyph_cols,
  input  logic signed [7:0] glyph_top,
  input  logic signed [7:0] glyph_left,
  input  logic [7:0]  glyph_advance,
  input  logic [7:0]  sample_value,
  input  logic signed [7:0] kern_offset,
  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        pixel_valid,
  output logic [15:0] pixel_addr,
  output logic [6:0]  pixel_char,
  output logic        status,
  output logic signed [9:0] advance_out,
  output logic        last
);

  typedef enum logic [2:0] {
    S_IDLE, S_META, S_KWAIT, S_ROW, S_COL, S_PIX, S_FIN, S_ERR
  } state_t;

  state_t state;

  // Configuration registers.
  logic [8:0]        buf_width;
  logic [8:0]        buf_height;
  logic signed [7:0] ascender;
  logic [7:0]        max_glyph;

  // Load state.
  logic [GLYPH_SLOTS-1:0] stored_valid;
  logic [5:0]             sample_pointer;
  logic [7:0]             loading_glyph;

  // Draw state.
  logic [7:0]         code;
  logic signed [10:0] px;
  logic signed [10:0] py;
  metric_t            met;
  logic [3:0]         r;
  logic [3:0]         c;
  logic [6:0]         base;
  logic signed [12:0] yofs0;
  logic signed [12:0] xofs0;
  logic signed [12:0] xc;
  logic [8:0]         cur_y;
  logic [15:0]        pix_addr;
  logic signed [9:0]  adv;
  logic               pend_v;
  logic [15:0]        pend_addr;
  logic [6:0]         pend_char;

  logic        accept;
  logic        out_free;
  logic        out_send;
  logic        missing;
  logic [3:0]  in_rows_sat;
  logic [3:0]  in_cols_sat;
  metric_t     met_wdata;
  metric_t     met_rdata;
  logic [7:0]  bmp_rdata;
  logic        bmp_we;
  logic [BMP_AW-1:0] bmp_waddr;
  logic [BMP_AW-1:0] bmp_raddr;
  logic signed [12:0] yc;
  kern_wr_t    kwr;
  kern_req_t   kreq;
  kern_res_t   kres;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // A new output beat is loaded in this cycle.
  assign out_send = out_free && (((state == S_PIX) && pend_v) || (state == S_FIN)
                                 || (state == S_ERR));

  // Missing glyph check on the incoming code.
  assign missing = (glyph_code > max_glyph) || ({1'b0, glyph_code} >= 9'(GLYPH_SLOTS))
                || !stored_valid[glyph_code[SLOT_W-1:0]];

  // Saturated bitmap size of a metrics load.
  assign in_rows_sat = (glyph_rows > 4'(MAX_GLYPH_DIM)) ? 4'(MAX_GLYPH_DIM) : glyph_rows;
  assign in_cols_sat = (glyph_cols > 4'(MAX_GLYPH_DIM)) ? 4'(MAX_GLYPH_DIM) : glyph_cols;

  assign met_wdata.rows    = in_rows_sat;
  assign met_wdata.cols    = in_cols_sat;
  assign met_wdata.top     = glyph_top;
  assign met_wdata.left    = glyph_left;
  assign met_wdata.advance = glyph_advance;

  gbk_ram #(
    .WIDTH($bits(metric_t)),
    .DEPTH(GLYPH_SLOTS)
  ) u_metrics (
    .clk  (clk),
    .we   (accept && (cmd == CMD_METRICS) && ({1'b0, glyph_code} < 9'(GLYPH_SLOTS))),
    .waddr(glyph_code[SLOT_W-1:0]),
    .wdata(met_wdata),
    .raddr(glyph_code[SLOT_W-1:0]),
    .rdata(met_rdata)
  );

  // Bitmap addresses: slot times glyph area plus the row-major index.
  assign bmp_we = accept && (cmd == CMD_SAMPLE)
               && ({1'b0, loading_glyph} < 9'(GLYPH_SLOTS))
               && ({1'b0, sample_pointer} < 7'(GLYPH_AREA));
  assign bmp_waddr = BMP_AW'(loading_glyph[SLOT_W-1:0]) * BMP_AW'(GLYPH_AREA)
                   + BMP_AW'(sample_pointer[IDX_W-1:0]);
  assign bmp_raddr = BMP_AW'(code[SLOT_W-1:0]) * BMP_AW'(GLYPH_AREA)
                   + BMP_AW'(7'(base + 7'(c)));

  gbk_ram #(
    .WIDTH(8),
    .DEPTH(BMP_DEPTH)
  ) u_bitmap (
    .clk  (clk),
    .we   (bmp_we),
    .waddr(bmp_waddr),
    .wdata(sample_value),
    .raddr(bmp_raddr),
    .rdata(bmp_rdata)
  );

  assign kwr.en           = accept && (cmd == CMD_KERN);
  assign kwr.entry.right  = glyph_code;
  assign kwr.entry.left   = other_code;
  assign kwr.entry.offset = kern_offset;
  assign kreq.start       = accept && (cmd == CMD_DRAW) && !missing;
  assign kreq.left        = other_code;
  assign kreq.right       = glyph_code;

  gbk_kern u_kern (
    .clk(clk),
    .rst(rst),
    .wr (kwr),
    .req(kreq),
    .res(kres)
  );

  // Vertical offset of the current row.
  assign yc = yofs0 + 13'(r);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_width  <= 9'd128;
      buf_height <= 9'd64;
      ascender   <= 8'sd12;
      max_glyph  <= 8'd127;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BUF_WIDTH:  buf_width  <= cfg_data;
        CFG_BUF_HEIGHT: buf_height <= cfg_data;
        CFG_ASCENDER:   ascender   <= cfg_data[7:0];
        CFG_MAX_GLYPH:  max_glyph  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Load bookkeeping, draw sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      stored_valid   <= '0;
      sample_pointer <= '0;
      loading_glyph  <= '0;
      pend_v         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_send) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_METRICS: begin
                if ({1'b0, glyph_code} < 9'(GLYPH_SLOTS)) begin
                  stored_valid[glyph_code[SLOT_W-1:0]] <= 1'b1;
                  loading_glyph  <= glyph_code;
                  sample_pointer <= '0;
                end
              end
              CMD_SAMPLE: sample_pointer <= sample_pointer + 1'b1;
              CMD_KERN: ;
              default: begin
                code  <= glyph_code;
                px    <= pos_x;
                py    <= pos_y;
                state <= missing ? S_ERR : S_META;
              end
            endcase
          end
        end
        S_META: begin
          met   <= met_rdata;
          state <= S_KWAIT;
        end
        S_KWAIT: begin
          if (!kres.busy) begin
            yofs0 <= 13'(py) + 13'(ascender) - 13'($signed(met.top));
            xofs0 <= 13'(px) + 13'($signed(met.left)) + 13'($signed(kres.offset));
            adv   <= $signed({2'b00, met.advance}) + 10'($signed(kres.offset));
            r     <= '0;
            base  <= '0;
            state <= S_ROW;
          end
        end
        S_ROW: begin
          if ((r >= met.rows) || (yc >= $signed({4'b0000, buf_height}))) begin
            state <= S_FIN;
          end else if (yc < 0) begin
            r    <= r + 1'b1;
            base <= base + 7'(met.cols);
          end else begin
            cur_y <= yc[8:0];
            c     <= '0;
            xc    <= xofs0;
            state <= S_COL;
          end
        end
        S_COL: begin
          if ((c >= met.cols) || (xc >= $signed({4'b0000, buf_width}))) begin
            r     <= r + 1'b1;
            base  <= base + 7'(met.cols);
            state <= S_ROW;
          end else if (xc < 0) begin
            c  <= c + 1'b1;
            xc <= xc + 13'sd1;
          end else begin
            pix_addr <= 16'(cur_y * buf_width + 18'(xc[8:0]));
            state    <= S_PIX;
          end
        end
        S_PIX: begin
          // The previous pixel goes out once this one shows it was not last.
          if (!pend_v || out_free) begin
            if (pend_v) begin
              pixel_valid <= 1'b1;
              pixel_addr  <= pend_addr;
              pixel_char  <= pend_char;
              status      <= 1'b0;
              advance_out <= adv;
              last        <= 1'b0;
            end
            pend_v    <= 1'b1;
            pend_addr <= pix_addr;
            pend_char <= level_char(bmp_rdata);
            c         <= c + 1'b1;
            xc        <= xc + 13'sd1;
            state     <= S_COL;
          end
        end
        S_FIN: begin
          if (out_free) begin
            pixel_valid <= pend_v;
            pixel_addr  <= pend_v ? pend_addr : 16'd0;
            pixel_char  <= pend_v ? pend_char : 7'd0;
            status      <= 1'b0;
            advance_out <= adv;
            last        <= 1'b1;
            pend_v      <= 1'b0;
            state       <= S_IDLE;
          end
        end
        S_ERR: begin
          if (out_free) begin
            pixel_valid <= 1'b0;
            pixel_addr  <= 16'd0;
            pixel_char  <= 7'd0;
            status      <= 1'b1;
            advance_out <= 10'sd0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Assertions.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_v)
    else $error("pixel left pending between draws");
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pixel_valid) |-> last)
    else $error("result without a pixel is not the last of its draw");
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (!pixel_valid && (advance_out == 10'sd0)))
    else $error("error result carries a pixel or an advance");
  a_kern_in_draw: assert property (@(posedge clk) disable iff (rst)
    kres.busy |-> ((state == S_META) || (state == S_KWAIT)))
    else $error("kerning scan running outside a draw");

endmodule

FILE: hw/rtl/gbk_ram.sv
// ----------------------------------------------------------------------------
// gbk_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/gbk_kern.sv
// ----------------------------------------------------------------------------
// gbk_kern: kerning pair store and search
// Appends pairs to a memory and scans it for the first pair that matches a
// glyph pair, one entry per cycle.
// ----------------------------------------------------------------------------
module gbk_kern
  import gbk_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  kern_wr_t  wr,
  input  kern_req_t req,
  output kern_res_t res
);

  logic [KC_W-1:0] count;
  logic [KC_W-1:0] limit;
  logic [KC_W-1:0] kidx;
  logic            kvld;
  logic            busy;
  logic [7:0]      want_left;
  logic [7:0]      want_right;
  logic [7:0]      offset;
  logic            issue;
  logic            match;
  kern_entry_t     rd_entry;

  gbk_ram #(
    .WIDTH($bits(kern_entry_t)),
    .DEPTH(KERN_PAIRS)
  ) u_ram (
    .clk  (clk),
    .we   (wr.en && (count < KC_W'(KERN_PAIRS))),
    .waddr(count[KA_W-1:0]),
    .wdata(wr.entry),
    .raddr(kidx[KA_W-1:0]),
    .rdata(rd_entry)
  );

  assign issue = kidx < limit;
  assign match = kvld && (rd_entry.right == want_right) && (rd_entry.left == want_left);

  // Pair count, and the scan: one read issued and one entry compared a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
      kvld  <= 1'b0;
      kidx  <= '0;
    end else begin
      if (wr.en && (count < KC_W'(KERN_PAIRS))) begin
        count <= count + 1'b1;
      end
      if (req.start) begin
        busy       <= 1'b1;
        kvld       <= 1'b0;
        kidx       <= '0;
        offset     <= '0;
        want_left  <= req.left;
        want_right <= req.right;
        // A zero code never matches, so the scan covers no entry.
        limit      <= ((req.left == 8'd0) || (req.right == 8'd0)) ? '0 : count;
      end else if (busy) begin
        if (match) begin
          offset <= rd_entry.offset;
          busy   <= 1'b0;
          kvld   <= 1'b0;
        end else if (!issue) begin
          busy <= 1'b0;
          kvld <= 1'b0;
        end else begin
          kidx <= kidx + 1'b1;
          kvld <= 1'b1;
        end
      end
    end
  end

  assign res.busy   = busy;
  assign res.offset = offset;

  // Assertions.
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (kidx <= limit))
    else $error("kerning scan index beyond pair count");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    count <= KC_W'(KERN_PAIRS))
    else $error("kerning pair count overflow");
  a_match_ends: assert property (@(posedge clk) disable iff (rst)
    (busy && match && !req.start) |=> !busy)
    else $error("kerning scan went on after a match");

endmodule
